>>> rtl/pfrm_pkg.sv
// Shared types, constants and codes for the pulse flow rate meter.
package pfrm_pkg;

	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 40;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam int unsigned DIV_NUM_W = 48;
	localparam int unsigned DIV_DEN_W = 56;
	localparam int unsigned DIV_CNT_W = 6;

	// 3600 * 1000 * 256
	localparam logic [29:0] RATE_NUM = 30'd921600000;
	localparam logic [DIV_CNT_W-1:0] RATE_STEPS  = 6'd30;
	localparam logic [DIV_CNT_W-1:0] ALPHA_STEPS = 6'd48;
	localparam logic [16:0] Q16_ONE = 17'h10000;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PPL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TC       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;

	localparam logic [15:0] RST_DEBOUNCE = 16'd5;
	localparam logic [23:0] RST_PPL      = 24'd115200;
	localparam logic [15:0] RST_TC       = 16'd1000;
	localparam logic [31:0] RST_TIMEOUT  = 32'd2000;
	localparam logic [31:0] RST_LIMIT    = 32'd2000;

	localparam logic [1:0] PH_WAIT_FIRST  = 2'd0;
	localparam logic [1:0] PH_WAIT_SECOND = 2'd1;
	localparam logic [1:0] PH_PAIR        = 2'd2;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [23:0] pulses_per_liter_q8;
		logic [15:0] filter_tc_ms;
		logic [31:0] idle_limit_ms;
		logic [31:0] estimate_limit_ms;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic [15:0] flow_estimate_l_h;
		logic [15:0] smoothed_flow_lph;
		logic        new_reading;
		logic        flowing;
		logic [1:0]  capture_phase;
	} res_t;

endpackage

>>> rtl/pulse_flow_rate_meter.sv
// Top level of the pulse flow rate meter: register file, stream ports, output register.
//
// channel  dir  handshake                     payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata[0] pulse
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata[15:0] estimate, [31:16] filtered,
//                                             [32] new_reading, [33] flowing, [35:34] phase
// cfg      in   cfg_we                        cfg_index, cfg_data
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Items with no division skip the divider; a decay estimate or a new reading uses
// the one serial divider (one quotient bit per cycle).
// Asynchronous reset returns the meter state and control registers to their defaults;
// no clearing pass.
// The output register frees the sequencer as soon as m_axis is not stalled.
module pulse_flow_rate_meter import pfrm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] pulse
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // flow_estimate_l_h, smoothed_flow_lph,
	                                               // new_reading, flowing, capture_phase
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t     cfg_q;
	div_req_t div_req;
	div_rsp_t div_rsp;
	res_t     res;
	logic     core_ready;
	logic     res_valid;
	logic     load;
	logic     m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms         <= RST_DEBOUNCE;
			cfg_q.pulses_per_liter_q8 <= RST_PPL;
			cfg_q.filter_tc_ms        <= RST_TC;
			cfg_q.idle_limit_ms       <= RST_TIMEOUT;
			cfg_q.estimate_limit_ms   <= RST_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms         <= cfg_data[15:0];
				REG_PPL:      cfg_q.pulses_per_liter_q8 <= cfg_data[23:0];
				REG_TC:       cfg_q.filter_tc_ms        <= cfg_data[15:0];
				REG_TIMEOUT:  cfg_q.idle_limit_ms       <= cfg_data;
				REG_LIMIT:    cfg_q.estimate_limit_ms   <= cfg_data;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign s_axis_tready = core_ready;
	assign load = res_valid && (!m_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (load)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			m_data_q <= {4'b0, res.capture_phase, res.flowing, res.new_reading,
				res.smoothed_flow_lph, res.flow_estimate_l_h};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	pfrm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (s_axis_tvalid && core_ready),
		.pulse     (s_axis_tdata[0]),
		.ready     (core_ready),
		.res_valid (res_valid),
		.res_take  (load),
		.res       (res),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	pfrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

>>> rtl/pfrm_div.sv
// Shared restoring divider, one quotient bit per cycle.
module pfrm_div import pfrm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;

	logic [DIV_DEN_W:0] trial;
	logic [DIV_DEN_W:0] trial_sub;
	logic               ge;

	assign trial     = {rem_q, num_q[DIV_NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			num_q <= req.num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

>>> rtl/pfrm_core.sv
// Sequencer, meter state and shared multiplier of the flow rate meter.
module pfrm_core import pfrm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     start,
	input  logic     pulse,
	output logic     ready,
	output logic     res_valid,
	input  logic     res_take,
	output res_t     res,
	output div_req_t div_req,
	input  div_rsp_t div_rsp
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_CHECK     = 4'd1;
	localparam logic [3:0] S_RMUL      = 4'd2;
	localparam logic [3:0] S_RDIV_GO   = 4'd3;
	localparam logic [3:0] S_RDIV_WAIT = 4'd4;
	localparam logic [3:0] S_ADIV_GO   = 4'd5;
	localparam logic [3:0] S_ADIV_WAIT = 4'd6;
	localparam logic [3:0] S_FMUL_A    = 4'd7;
	localparam logic [3:0] S_FMUL_B    = 4'd8;
	localparam logic [3:0] S_FACC      = 4'd9;
	localparam logic [3:0] S_EST       = 4'd10;
	localparam logic [3:0] S_DONE      = 4'd11;

	logic [3:0]  state_q;
	logic [31:0] time_q;
	logic [31:0] last_edge_q;
	logic [31:0] first_q;
	logic [31:0] second_q;
	logic [1:0]  phase_q;
	logic [31:0] acc_q;
	logic [31:0] last_period_q;
	logic [31:0] last_update_q;
	logic [15:0] held_q;
	logic        fresh_q;
	logic        reading_q;

	logic [31:0] op_q;
	logic [15:0] raw_q;
	logic [16:0] alpha_q;
	logic [31:0] term_q;
	logic [55:0] mul_q;
	logic [15:0] est_q;

	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic [15:0] raw_sat;
	logic [31:0] edge_gap;
	logic [31:0] upd_gap;
	logic [31:0] acc_new;
	logic [32:0] alpha_den;

	assign edge_gap  = time_q - last_edge_q;
	assign upd_gap   = time_q - last_update_q;
	assign raw_sat   = (div_rsp.quo[DIV_NUM_W-1:16] != '0) ? 16'hFFFF : div_rsp.quo[15:0];
	assign acc_new   = term_q + mul_q[47:16];
	assign alpha_den = {17'b0, cfg.filter_tc_ms} + {1'b0, op_q};

	always_comb begin
		mul_a = op_q;
		mul_b = cfg.pulses_per_liter_q8;
		unique case (state_q)
			S_FMUL_A: begin
				mul_a = {16'b0, raw_q};
				mul_b = {7'b0, alpha_q};
			end
			S_FMUL_B: begin
				mul_a = acc_q;
				mul_b = {7'b0, Q16_ONE - alpha_q};
			end
			default: begin
				mul_a = op_q;
				mul_b = cfg.pulses_per_liter_q8;
			end
		endcase
	end

	always_comb begin
		div_req.start = (state_q == S_RDIV_GO) || (state_q == S_ADIV_GO);
		if (state_q == S_ADIV_GO) begin
			div_req.num   = {op_q, 16'b0};
			div_req.den   = {23'b0, alpha_den};
			div_req.steps = ALPHA_STEPS;
		end else begin
			div_req.num   = {RATE_NUM, 18'b0};
			div_req.den   = mul_q;
			div_req.steps = RATE_STEPS;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		unique case (state_q)
			S_CHECK:     op_q <= second_q - first_q;
			S_EST:       op_q <= upd_gap;
			default:     op_q <= op_q;
		endcase
		if (state_q == S_RDIV_WAIT && div_rsp.done)
			raw_q <= raw_sat;
		if (state_q == S_ADIV_WAIT && div_rsp.done)
			alpha_q <= div_rsp.quo[16:0];
		if (state_q == S_FMUL_B)
			term_q <= mul_q[31:0];
		if (state_q == S_RDIV_WAIT && div_rsp.done && !reading_q)
			est_q <= raw_sat;
		else if (state_q == S_EST &&
			!(last_period_q < upd_gap && upd_gap < cfg.estimate_limit_ms))
			est_q <= held_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			time_q        <= '0;
			last_edge_q   <= '0;
			first_q       <= '0;
			second_q      <= '0;
			phase_q       <= PH_WAIT_FIRST;
			acc_q         <= '0;
			last_period_q <= '0;
			last_update_q <= '0;
			held_q        <= '0;
			fresh_q       <= 1'b0;
			reading_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						fresh_q <= 1'b0;
						state_q <= S_CHECK;
						if (pulse && edge_gap >= {16'b0, cfg.debounce_ms}) begin
							last_edge_q <= time_q;
							unique case (phase_q)
								PH_WAIT_FIRST: begin
									first_q <= time_q;
									phase_q <= PH_WAIT_SECOND;
								end
								PH_WAIT_SECOND: begin
									second_q <= time_q;
									phase_q  <= PH_PAIR;
								end
								default: begin
									first_q  <= second_q;
									second_q <= time_q;
									phase_q  <= PH_PAIR;
								end
							endcase
						end
					end
				end
				S_CHECK: begin
					if (phase_q == PH_PAIR) begin
						first_q   <= second_q;
						phase_q   <= PH_WAIT_SECOND;
						reading_q <= second_q != first_q;
						state_q   <= (second_q != first_q) ? S_RMUL : S_EST;
					end else begin
						reading_q <= 1'b0;
						state_q   <= S_EST;
						if (upd_gap > cfg.idle_limit_ms) begin
							held_q <= '0;
							acc_q  <= '0;
							if (edge_gap > cfg.idle_limit_ms)
								phase_q <= PH_WAIT_FIRST;
						end
					end
				end
				S_RMUL:    state_q <= S_RDIV_GO;
				S_RDIV_GO: state_q <= S_RDIV_WAIT;
				S_RDIV_WAIT: begin
					if (div_rsp.done)
						state_q <= reading_q ? S_ADIV_GO : S_DONE;
				end
				S_ADIV_GO: state_q <= S_ADIV_WAIT;
				S_ADIV_WAIT: begin
					if (div_rsp.done)
						state_q <= S_FMUL_A;
				end
				S_FMUL_A: state_q <= S_FMUL_B;
				S_FMUL_B: state_q <= S_FACC;
				S_FACC: begin
					acc_q         <= acc_new;
					held_q        <= acc_new[31:16];
					last_period_q <= op_q;
					last_update_q <= time_q;
					fresh_q       <= 1'b1;
					state_q       <= S_EST;
				end
				S_EST: begin
					if (last_period_q < upd_gap && upd_gap < cfg.estimate_limit_ms) begin
						reading_q <= 1'b0;
						state_q   <= S_RMUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						time_q  <= time_q + 32'd1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ready     = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;

	assign res.flow_estimate_l_h = est_q;
	assign res.smoothed_flow_lph = held_q;
	assign res.new_reading       = fresh_q;
	assign res.flowing           = est_q != 16'd0;
	assign res.capture_phase     = phase_q;

endmodule

>>> rtl/pfrm_checker.sv
// Port-level checks for the pulse flow rate meter, bound to the top level.
module pfrm_checker import pfrm_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata    // estimate, filtered, new, flowing, phase
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is in work");

	a_no_pair_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[35:34] != PH_PAIR)
		else $error("pair left unconsumed at output");

	a_flowing: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[33] == (m_axis_tdata[15:0] != 16'd0))
		else $error("flowing flag disagrees with estimate");

	a_reading_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[35:34] == PH_WAIT_SECOND)
		else $error("new reading without re-armed capture");

endmodule

bind pulse_flow_rate_meter pfrm_checker u_pfrm_checker (.*);
